// ===== hw/rtl/sdf_pkg.sv =====
`timescale 1ns / 1ps
package sdf_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int COEF_BITS  = WORD_BITS - 1;
    localparam int DIFF_W     = WORD_BITS + 1;
    localparam int SCL_W      = 30;
    localparam int SH_MAX     = DIFF_W - SCL_W;
    localparam int SH_W       = $clog2(SH_MAX + 1);
    localparam int SQ_W       = 2 * SCL_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int ROOT_W     = SCL_W + 1;
    localparam int SQRT_STEPS = SUM_W / 2;
    localparam int LEN_W      = ROOT_W + SH_MAX;
    localparam int DLT_W      = LEN_W + 1;
    localparam int Q_W        = FRAC_BITS + 1;
    localparam int VEL_PW     = WORD_BITS + Q_W;
    localparam int TM_W       = VEL_PW - FRAC_BITS;
    localparam int VDOT_W     = WORD_BITS + 2;
    localparam int SK_PW      = COEF_BITS + LEN_W;
    localparam int DM_PW      = COEF_BITS + VDOT_W - 1;
    localparam int SK_W       = SK_PW - FRAC_BITS;
    localparam int DM_W       = DM_PW - FRAC_BITS;
    localparam int FSC_W      = SK_W + 2;
    localparam int FP_W       = FSC_W - 1 + Q_W;
    localparam int FA_W       = FP_W - FRAC_BITS;
    localparam int IN_W       = ((9 * WORD_BITS + 3 * COEF_BITS + 7) / 8) * 8;
    localparam int OUT_W      = ((6 * WORD_BITS + 7) / 8) * 8;
    localparam int STAT_W     = 2;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_SAT  = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0][WORD_BITS-1:0] pos_a;
        logic [2:0][WORD_BITS-1:0] pos_b;
        logic [2:0][WORD_BITS-1:0] vel;
        logic [COEF_BITS-1:0]      rest;
        logic [COEF_BITS-1:0]      stiff;
        logic [COEF_BITS-1:0]      damp;
    } t_in;

    typedef struct packed {
        logic [2:0][WORD_BITS-1:0] vel;
        logic [COEF_BITS-1:0]      rest;
        logic [COEF_BITS-1:0]      stiff;
        logic [COEF_BITS-1:0]      damp;
        logic [2:0][SCL_W-1:0]     smag;
        logic [2:0]                sneg;
        logic [SH_W-1:0]           sh;
        logic                      zero;
    } t_ctx;

    typedef struct packed {
        t_ctx             ctx;
        logic [SUM_W-1:0] sum;
    } t_fe;

    typedef struct packed {
        t_ctx              ctx;
        logic [ROOT_W-1:0] root;
    } t_sq;

    typedef struct packed {
        t_ctx                  ctx;
        logic [ROOT_W-1:0]     root;
        logic [2:0][Q_W-1:0]   u;
    } t_dv;

    typedef struct packed {
        logic [2:0][WORD_BITS-1:0] fa;
        logic [2:0][WORD_BITS-1:0] fb;
        t_status                   status;
    } t_out;

endpackage

// ===== hw/rtl/sdf_front.sv =====
`timescale 1ns / 1ps
module sdf_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  sdf_pkg::t_in i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output sdf_pkg::t_fe o_data
);
    localparam int NSTG = 4;

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] w_rdy;

    logic [2:0][sdf_pkg::DIFF_W-1:0] n_d, r_d;
    sdf_pkg::t_ctx                   n_c1, r_c1, n_c2, r_c2, r_c3, r_c4;
    logic [2:0][sdf_pkg::SQ_W-1:0]   n_sq, r_sq;
    logic [sdf_pkg::SUM_W-1:0]       n_sum, r_sum;

    always_comb begin
        for (int k = NSTG - 1; k >= 0; k--) begin
            if (k == NSTG - 1) begin
                w_rdy[k] = !r_v[k] || i_ready;
            end else begin
                w_rdy[k] = !r_v[k] || w_rdy[k+1];
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NSTG-1];
    assign o_data.ctx = r_c4;
    assign o_data.sum = r_sum;

    always_comb begin
        n_c1       = '0;
        n_c1.vel   = i_data.vel;
        n_c1.rest  = i_data.rest;
        n_c1.stiff = i_data.stiff;
        n_c1.damp  = i_data.damp;
        for (int i = 0; i < 3; i++) begin
            n_d[i] = sdf_pkg::DIFF_W'($signed(i_data.pos_a[i]))
                   - sdf_pkg::DIFF_W'($signed(i_data.pos_b[i]));
        end
    end

    always_comb begin
        logic [2:0][sdf_pkg::DIFF_W-1:0] w_mag;
        logic [sdf_pkg::DIFF_W-1:0]      w_max;
        n_c2  = r_c1;
        w_max = '0;
        for (int i = 0; i < 3; i++) begin
            n_c2.sneg[i] = r_d[i][sdf_pkg::DIFF_W-1];
            w_mag[i] = r_d[i][sdf_pkg::DIFF_W-1] ? (~r_d[i] + 1'b1) : r_d[i];
            if (w_mag[i] > w_max) begin
                w_max = w_mag[i];
            end
        end
        n_c2.sh = '0;
        for (int k = sdf_pkg::SH_MAX; k >= 0; k--) begin
            if ((w_max >> k) < (sdf_pkg::DIFF_W'(1) << sdf_pkg::SCL_W)) begin
                n_c2.sh = sdf_pkg::SH_W'(k);
            end
        end
        for (int i = 0; i < 3; i++) begin
            n_c2.smag[i] = sdf_pkg::SCL_W'(w_mag[i] >> n_c2.sh);
        end
        n_c2.zero = (w_max == '0);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sq[i] = sdf_pkg::SQ_W'(r_c2.smag[i]) * sdf_pkg::SQ_W'(r_c2.smag[i]);
        end
        n_sum = sdf_pkg::SUM_W'(r_sq[0]) + sdf_pkg::SUM_W'(r_sq[1])
              + sdf_pkg::SUM_W'(r_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_d  <= n_d;
            r_c1 <= n_c1;
        end
        if (w_rdy[1]) begin
            r_c2 <= n_c2;
        end
        if (w_rdy[2]) begin
            r_c3 <= r_c2;
            r_sq <= n_sq;
        end
        if (w_rdy[3]) begin
            r_c4  <= r_c3;
            r_sum <= n_sum;
        end
    end

endmodule

// ===== hw/rtl/sdf_sqrt.sv =====
`timescale 1ns / 1ps
module sdf_sqrt (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  sdf_pkg::t_fe i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output sdf_pkg::t_sq o_data
);
    localparam int NSTG = sdf_pkg::SQRT_STEPS;

    typedef struct packed {
        sdf_pkg::t_ctx             ctx;
        logic [sdf_pkg::SUM_W-1:0] x;
        logic [sdf_pkg::SUM_W-1:0] res;
    } t_sqs;

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] w_rdy;
    t_sqs            r_s [NSTG];
    t_sqs            n_s [NSTG];

    always_comb begin
        for (int k = NSTG - 1; k >= 0; k--) begin
            if (k == NSTG - 1) begin
                w_rdy[k] = !r_v[k] || i_ready;
            end else begin
                w_rdy[k] = !r_v[k] || w_rdy[k+1];
            end
        end
    end

    assign o_ready     = w_rdy[0];
    assign o_valid     = r_v[NSTG-1];
    assign o_data.ctx  = r_s[NSTG-1].ctx;
    assign o_data.root = r_s[NSTG-1].res[sdf_pkg::ROOT_W-1:0];

    always_comb begin
        t_sqs                      w_p;
        logic [sdf_pkg::SUM_W-1:0] w_one;
        logic [sdf_pkg::SUM_W:0]   w_t;
        for (int k = 0; k < NSTG; k++) begin
            if (k == 0) begin
                w_p.ctx = i_data.ctx;
                w_p.x   = i_data.sum;
                w_p.res = '0;
            end else begin
                w_p = r_s[k-1];
            end
            w_one  = sdf_pkg::SUM_W'(1) << (sdf_pkg::SUM_W - 2 - 2 * k);
            w_t    = {1'b0, w_p.res} + {1'b0, w_one};
            n_s[k] = w_p;
            if ({1'b0, w_p.x} >= w_t) begin
                n_s[k].x   = w_p.x - w_t[sdf_pkg::SUM_W-1:0];
                n_s[k].res = (w_p.res >> 1) + w_one;
            end else begin
                n_s[k].res = w_p.res >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (w_rdy[k]) begin
                r_s[k] <= n_s[k];
            end
        end
    end

endmodule

// ===== hw/rtl/sdf_div.sv =====
`timescale 1ns / 1ps
module sdf_div (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  sdf_pkg::t_sq i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output sdf_pkg::t_dv o_data
);
    localparam int NSTG = sdf_pkg::Q_W;

    typedef struct packed {
        sdf_pkg::t_ctx                     ctx;
        logic [sdf_pkg::ROOT_W-1:0]        root;
        logic [2:0][sdf_pkg::ROOT_W-1:0]   rem;
        logic [2:0][sdf_pkg::Q_W-1:0]      q;
    } t_dvs;

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] w_rdy;
    t_dvs            r_s [NSTG];
    t_dvs            n_s [NSTG];

    always_comb begin
        for (int k = NSTG - 1; k >= 0; k--) begin
            if (k == NSTG - 1) begin
                w_rdy[k] = !r_v[k] || i_ready;
            end else begin
                w_rdy[k] = !r_v[k] || w_rdy[k+1];
            end
        end
    end

    assign o_ready     = w_rdy[0];
    assign o_valid     = r_v[NSTG-1];
    assign o_data.ctx  = r_s[NSTG-1].ctx;
    assign o_data.root = r_s[NSTG-1].root;
    assign o_data.u    = r_s[NSTG-1].q;

    always_comb begin
        t_dvs                        w_p;
        logic                        w_bit;
        logic [sdf_pkg::ROOT_W:0]    w_t;
        for (int k = 0; k < NSTG; k++) begin
            if (k == 0) begin
                w_p.ctx  = i_data.ctx;
                w_p.root = i_data.root;
                w_p.q    = '0;
                for (int i = 0; i < 3; i++) begin
                    w_p.rem[i] = sdf_pkg::ROOT_W'(i_data.ctx.smag[i] >> 1);
                end
            end else begin
                w_p = r_s[k-1];
            end
            n_s[k] = w_p;
            for (int i = 0; i < 3; i++) begin
                w_bit = (k == 0) ? w_p.ctx.smag[i][0] : 1'b0;
                w_t   = {w_p.rem[i], w_bit};
                if (w_t >= {1'b0, w_p.root}) begin
                    n_s[k].rem[i] = sdf_pkg::ROOT_W'(w_t - {1'b0, w_p.root});
                    n_s[k].q[i]   = {w_p.q[i][sdf_pkg::Q_W-2:0], 1'b1};
                end else begin
                    n_s[k].rem[i] = w_t[sdf_pkg::ROOT_W-1:0];
                    n_s[k].q[i]   = {w_p.q[i][sdf_pkg::Q_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (w_rdy[k]) begin
                r_s[k] <= n_s[k];
            end
        end
    end

endmodule

// ===== hw/rtl/sdf_force.sv =====
`timescale 1ns / 1ps
module sdf_force (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sdf_pkg::t_dv  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output sdf_pkg::t_out o_data
);
    localparam int NSTG = 6;
    localparam int WB   = sdf_pkg::WORD_BITS;
    localparam logic signed [sdf_pkg::FA_W:0] W_MAX =
        (sdf_pkg::FA_W+1)'({1'b0, {(WB-1){1'b1}}});
    localparam logic signed [sdf_pkg::FA_W:0] W_MIN = ~W_MAX;

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] w_rdy;

    sdf_pkg::t_dv                      r_dv1, r_dv2, r_dv3, r_dv4, r_dv5;
    logic [2:0][sdf_pkg::VEL_PW-1:0]   n_pv1, r_pv1;
    logic [2:0]                        n_pneg1, r_pneg1;
    logic [sdf_pkg::DLT_W-1:0]         n_dlt1, r_dlt1, r_dlt2;
    logic [sdf_pkg::VDOT_W-1:0]        n_vdot2, r_vdot2;
    logic [sdf_pkg::SK_PW-1:0]         n_psk3, r_psk3;
    logic [sdf_pkg::DM_PW-1:0]         n_pdm3, r_pdm3;
    logic                              n_skneg3, r_skneg3, n_dmneg3, r_dmneg3;
    logic [sdf_pkg::FSC_W-1:0]         n_fsc4, r_fsc4;
    logic [2:0][sdf_pkg::FP_W-1:0]     n_pf5, r_pf5;
    logic [2:0]                        n_pneg5, r_pneg5;
    sdf_pkg::t_out                     n_out6, r_out6;

    always_comb begin
        for (int k = NSTG - 1; k >= 0; k--) begin
            if (k == NSTG - 1) begin
                w_rdy[k] = !r_v[k] || i_ready;
            end else begin
                w_rdy[k] = !r_v[k] || w_rdy[k+1];
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NSTG-1];
    assign o_data  = r_out6;

    always_comb begin
        logic [WB-1:0] w_vmag;
        logic          w_vneg;
        for (int i = 0; i < 3; i++) begin
            w_vneg     = i_data.ctx.vel[i][WB-1];
            w_vmag     = w_vneg ? (~i_data.ctx.vel[i] + 1'b1) : i_data.ctx.vel[i];
            n_pv1[i]   = sdf_pkg::VEL_PW'(w_vmag) * sdf_pkg::VEL_PW'(i_data.u[i]);
            n_pneg1[i] = w_vneg ^ i_data.ctx.sneg[i];
        end
        n_dlt1 = (sdf_pkg::DLT_W'(i_data.root) << i_data.ctx.sh)
               - sdf_pkg::DLT_W'(i_data.ctx.rest);
    end

    always_comb begin
        logic [sdf_pkg::TM_W-1:0] w_tm;
        n_vdot2 = '0;
        for (int i = 0; i < 3; i++) begin
            w_tm    = sdf_pkg::TM_W'(r_pv1[i] >> sdf_pkg::FRAC_BITS);
            n_vdot2 = n_vdot2 + (r_pneg1[i]
                    ? (sdf_pkg::VDOT_W'(0) - sdf_pkg::VDOT_W'(w_tm))
                    : sdf_pkg::VDOT_W'(w_tm));
        end
    end

    always_comb begin
        logic [sdf_pkg::DLT_W-1:0]  w_dabs;
        logic [sdf_pkg::VDOT_W-1:0] w_vabs;
        n_skneg3 = r_dlt2[sdf_pkg::DLT_W-1];
        n_dmneg3 = r_vdot2[sdf_pkg::VDOT_W-1];
        w_dabs   = n_skneg3 ? (~r_dlt2 + 1'b1) : r_dlt2;
        w_vabs   = n_dmneg3 ? (~r_vdot2 + 1'b1) : r_vdot2;
        n_psk3   = sdf_pkg::SK_PW'(r_dv2.ctx.stiff)
                 * sdf_pkg::SK_PW'(w_dabs[sdf_pkg::LEN_W-1:0]);
        n_pdm3   = sdf_pkg::DM_PW'(r_dv2.ctx.damp)
                 * sdf_pkg::DM_PW'(w_vabs[sdf_pkg::VDOT_W-2:0]);
    end

    always_comb begin
        logic [sdf_pkg::FSC_W-1:0] w_sa, w_sb;
        w_sa   = sdf_pkg::FSC_W'(r_psk3 >> sdf_pkg::FRAC_BITS);
        w_sb   = sdf_pkg::FSC_W'(r_pdm3 >> sdf_pkg::FRAC_BITS);
        w_sa   = r_skneg3 ? (sdf_pkg::FSC_W'(0) - w_sa) : w_sa;
        w_sb   = r_dmneg3 ? (sdf_pkg::FSC_W'(0) - w_sb) : w_sb;
        n_fsc4 = sdf_pkg::FSC_W'(0) - (w_sa + w_sb);
    end

    always_comb begin
        logic                        w_fneg;
        logic [sdf_pkg::FSC_W-1:0]   w_fabs;
        w_fneg = r_fsc4[sdf_pkg::FSC_W-1];
        w_fabs = w_fneg ? (~r_fsc4 + 1'b1) : r_fsc4;
        for (int i = 0; i < 3; i++) begin
            n_pf5[i]   = sdf_pkg::FP_W'(w_fabs[sdf_pkg::FSC_W-2:0])
                       * sdf_pkg::FP_W'(r_dv4.u[i]);
            n_pneg5[i] = w_fneg ^ r_dv4.ctx.sneg[i];
        end
    end

    always_comb begin
        logic [sdf_pkg::FA_W-1:0]   w_fm;
        logic signed [sdf_pkg::FA_W:0] w_fv;
        logic [WB-1:0]              w_fa, w_fb;
        logic                       w_sat;
        w_sat  = 1'b0;
        n_out6 = '0;
        for (int i = 0; i < 3; i++) begin
            w_fm = sdf_pkg::FA_W'(r_pf5[i] >> sdf_pkg::FRAC_BITS);
            w_fv = r_pneg5[i] ? ((sdf_pkg::FA_W+1)'(0) - (sdf_pkg::FA_W+1)'(w_fm))
                              : (sdf_pkg::FA_W+1)'(w_fm);
            if (w_fv > W_MAX) begin
                w_fa  = W_MAX[WB-1:0];
                w_sat = 1'b1;
            end else if (w_fv < W_MIN) begin
                w_fa  = W_MIN[WB-1:0];
                w_sat = 1'b1;
            end else begin
                w_fa = w_fv[WB-1:0];
            end
            if (w_fa == {1'b1, {(WB-1){1'b0}}}) begin
                w_fb  = ~w_fa;
                w_sat = 1'b1;
            end else begin
                w_fb = {WB{1'b0}} - w_fa;
            end
            n_out6.fa[i] = r_dv5.ctx.zero ? '0 : w_fa;
            n_out6.fb[i] = r_dv5.ctx.zero ? '0 : w_fb;
        end
        if (r_dv5.ctx.zero) begin
            n_out6.status = sdf_pkg::ST_ZERO;
        end else if (w_sat) begin
            n_out6.status = sdf_pkg::ST_SAT;
        end else begin
            n_out6.status = sdf_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_dv1   <= i_data;
            r_pv1   <= n_pv1;
            r_pneg1 <= n_pneg1;
            r_dlt1  <= n_dlt1;
        end
        if (w_rdy[1]) begin
            r_dv2   <= r_dv1;
            r_dlt2  <= r_dlt1;
            r_vdot2 <= n_vdot2;
        end
        if (w_rdy[2]) begin
            r_dv3    <= r_dv2;
            r_psk3   <= n_psk3;
            r_pdm3   <= n_pdm3;
            r_skneg3 <= n_skneg3;
            r_dmneg3 <= n_dmneg3;
        end
        if (w_rdy[3]) begin
            r_dv4  <= r_dv3;
            r_fsc4 <= n_fsc4;
        end
        if (w_rdy[4]) begin
            r_dv5   <= r_dv4;
            r_pf5   <= n_pf5;
            r_pneg5 <= n_pneg5;
        end
        if (w_rdy[5]) begin
            r_out6 <= n_out6;
        end
    end

endmodule

// ===== hw/rtl/spring_damper_force_core.sv =====
`timescale 1ns / 1ps
// From input transfer to output: 4 front stages, 31 square-root stages, 17 divider stages and
// 6 force stages, one register stage per step. Throughput is one spring per cycle unless
// the output stalls; every stage holds its item only while the next is full, so bubbles
// close up and a stalled output does not block input until the pipeline fills.
// The synchronous active-low reset clears all stage valid bits; data registers are not reset.
module spring_damper_force_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z, rel_vel_x, rel_vel_y,
    // rel_vel_z, rest_len, stiffness, damping, zero fill.
    input  logic [sdf_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // force_a_x, force_a_y, force_a_z, force_b_x, force_b_y, force_b_z.
    output logic [sdf_pkg::OUT_W-1:0]   m_axis_tdata,
    // status.
    output logic [sdf_pkg::STAT_W-1:0]  m_axis_tuser
);
    localparam int WB = sdf_pkg::WORD_BITS;
    localparam int CB = sdf_pkg::COEF_BITS;

    sdf_pkg::t_in  w_in;
    sdf_pkg::t_fe  w_fe;
    sdf_pkg::t_sq  w_sq;
    sdf_pkg::t_dv  w_dv;
    sdf_pkg::t_out w_out;
    logic          w_fe_v, w_fe_r, w_sq_v, w_sq_r, w_dv_v, w_dv_r;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_in.pos_a[i] = s_axis_tdata[i*WB +: WB];
            w_in.pos_b[i] = s_axis_tdata[(3+i)*WB +: WB];
            w_in.vel[i]   = s_axis_tdata[(6+i)*WB +: WB];
        end
        w_in.rest  = s_axis_tdata[9*WB +: CB];
        w_in.stiff = s_axis_tdata[9*WB+CB +: CB];
        w_in.damp  = s_axis_tdata[9*WB+2*CB +: CB];
    end

    always_comb begin
        m_axis_tdata = '0;
        for (int i = 0; i < 3; i++) begin
            m_axis_tdata[i*WB +: WB]     = w_out.fa[i];
            m_axis_tdata[(3+i)*WB +: WB] = w_out.fb[i];
        end
        m_axis_tuser = w_out.status;
    end

    sdf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (w_in),
        .o_valid (w_fe_v),
        .i_ready (w_fe_r),
        .o_data  (w_fe)
    );

    sdf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fe_v),
        .o_ready (w_fe_r),
        .i_data  (w_fe),
        .o_valid (w_sq_v),
        .i_ready (w_sq_r),
        .o_data  (w_sq)
    );

    sdf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sq_v),
        .o_ready (w_sq_r),
        .i_data  (w_sq),
        .o_valid (w_dv_v),
        .i_ready (w_dv_r),
        .o_data  (w_dv)
    );

    sdf_force u_force (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dv_v),
        .o_ready (w_dv_r),
        .i_data  (w_dv),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out)
    );

    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == sdf_pkg::ST_ZERO) |-> (m_axis_tdata == '0))
        else $error("zero-length spring with nonzero force");

    a_b_is_neg_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == sdf_pkg::ST_OK)
        |-> (m_axis_tdata[3*WB +: WB] == ({WB{1'b0}} - m_axis_tdata[0 +: WB])))
        else $error("force on b is not the negation of force on a");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output stage is empty");

endmodule

// ===== test/spring_damper_force_core_tb.sv =====
`timescale 1ns / 1ps
module spring_damper_force_core_tb;
    import sdf_pkg::*;

    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic [2:0][WORD_BITS-1:0] fa;
        logic [2:0][WORD_BITS-1:0] fb;
        t_status                   status;
    } t_force;

    class force_board;
        t_force pending[$];
        int     errors;

        function t_wide fx_mul(t_wide a, t_wide b, inout bit sat);
            t_wide x;
            t_wide y;
            t_wide p;
            t_wide lim;
            bit    neg;
            lim = t_wide'(1) <<< 61;
            x = (a < 0) ? -a : a;
            y = (b < 0) ? -b : b;
            neg = (a < 0) != (b < 0);
            p = (x * y) >>> FRAC_BITS;
            if (p > lim) begin
                sat = 1'b1;
                p = lim;
            end
            return neg ? -p : p;
        endfunction

        function t_wide root_of(t_wide v);
            logic [63:0] x;
            logic [63:0] res;
            logic [63:0] one;
            x = v[63:0];
            res = 64'd0;
            one = 64'd1 << 62;
            for (int i = 0; i < 32; i++) begin
                if (x >= res + one) begin
                    x = x - (res + one);
                    res = (res >> 1) + one;
                end else begin
                    res = res >> 1;
                end
                one = one >> 2;
            end
            return t_wide'(res);
        endfunction

        function t_wide clamp_word(t_wide v, inout bit sat);
            t_wide hi;
            hi = (t_wide'(1) <<< (WORD_BITS - 1)) - 1;
            if (v > hi) begin
                sat = 1'b1;
                return hi;
            end
            if (v < -hi - 1) begin
                sat = 1'b1;
                return -hi - 1;
            end
            return v;
        endfunction

        function t_force predict_force(logic [IN_W-1:0] data);
            t_force f;
            int     pa, pb, vi;
            t_wide  d[3], mag[3], u[3], vel[3];
            t_wide  m, sum, r, len, rest, stiff, damp, vdot, fsc, fa, fb;
            int     sh;
            bit     sat;
            m = 0;
            sum = 0;
            sat = 1'b0;
            for (int i = 0; i < 3; i++) begin
                pa = data[32*i +: 32];
                pb = data[96 + 32*i +: 32];
                vi = data[192 + 32*i +: 32];
                d[i] = t_wide'(pa) - t_wide'(pb);
                vel[i] = t_wide'(vi);
                mag[i] = (d[i] < 0) ? -d[i] : d[i];
                if (mag[i] > m) m = mag[i];
            end
            rest = data[288 +: COEF_BITS];
            stiff = data[288 + COEF_BITS +: COEF_BITS];
            damp = data[288 + 2*COEF_BITS +: COEF_BITS];
            f = '0;
            if (m == 0) begin
                f.status = ST_ZERO;
                return f;
            end
            sh = 0;
            while ((m >>> sh) >= (t_wide'(1) <<< 30)) sh++;
            for (int i = 0; i < 3; i++) begin
                mag[i] = mag[i] >>> sh;
                sum = sum + mag[i] * mag[i];
            end
            r = root_of(sum);
            len = r <<< sh;
            for (int i = 0; i < 3; i++) begin
                u[i] = (mag[i] <<< FRAC_BITS) / r;
                if (d[i] < 0) u[i] = -u[i];
            end
            vdot = 0;
            for (int i = 0; i < 3; i++) vdot = vdot + fx_mul(vel[i], u[i], sat);
            fsc = -(fx_mul(stiff, len - rest, sat) + fx_mul(damp, vdot, sat));
            for (int i = 0; i < 3; i++) begin
                fa = clamp_word(fx_mul(fsc, u[i], sat), sat);
                fb = clamp_word(-fa, sat);
                f.fa[i] = fa[WORD_BITS-1:0];
                f.fb[i] = fb[WORD_BITS-1:0];
            end
            f.status = sat ? ST_SAT : ST_OK;
            return f;
        endfunction

        function void note_spring(logic [IN_W-1:0] data);
            pending.push_back(predict_force(data));
        endfunction

        function void check_force(logic [OUT_W-1:0] data, logic [STAT_W-1:0] user);
            t_force want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h status %0d", $time, data, user);
                errors++;
                return;
            end
            want = pending.pop_front();
            for (int i = 0; i < 3; i++) begin
                if (data[32*i +: 32] !== want.fa[i]) begin
                    $display("%0t: force_a[%0d] expected %h actual %h", $time, i,
                             want.fa[i], data[32*i +: 32]);
                    errors++;
                end
                if (data[96 + 32*i +: 32] !== want.fb[i]) begin
                    $display("%0t: force_b[%0d] expected %h actual %h", $time, i,
                             want.fb[i], data[96 + 32*i +: 32]);
                    errors++;
                end
            end
            if (user !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, user);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic [STAT_W-1:0] m_axis_tuser;

    force_board board;
    int         stall_pct;
    int         hold;

    spring_damper_force_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [IN_W-1:0] make_spring(int ax, int ay, int az, int bx, int by,
                                                    int bz, int vx, int vy, int vz,
                                                    int unsigned rest, int unsigned stiff,
                                                    int unsigned damp);
        logic [IN_W-1:0] d;
        d = '0;
        d[0 +: 32] = ax;
        d[32 +: 32] = ay;
        d[64 +: 32] = az;
        d[96 +: 32] = bx;
        d[128 +: 32] = by;
        d[160 +: 32] = bz;
        d[192 +: 32] = vx;
        d[224 +: 32] = vy;
        d[256 +: 32] = vz;
        d[288 +: COEF_BITS] = rest[COEF_BITS-1:0];
        d[288 + COEF_BITS +: COEF_BITS] = stiff[COEF_BITS-1:0];
        d[288 + 2*COEF_BITS +: COEF_BITS] = damp[COEF_BITS-1:0];
        return d;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < stall_pct) return $urandom_range(1, 3);
        if (p < stall_pct + 3) return $urandom_range(10, 40);
        return 0;
    endfunction

    task automatic send_spring(logic [IN_W-1:0] d);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    function automatic int rnd_signed(int bits);
        return $signed($urandom) >>> (32 - bits);
    endfunction

    function automatic logic [IN_W-1:0] random_spring();
        int          p;
        int          ax, ay, az;
        int unsigned mx;
        p = $urandom_range(0, 99);
        ax = rnd_signed(23);
        ay = rnd_signed(23);
        az = rnd_signed(23);
        mx = 32'h7fffffff;
        if (p < 65) begin
            return make_spring(ax, ay, az, rnd_signed(23), rnd_signed(23), rnd_signed(23),
                               rnd_signed(21), rnd_signed(21), rnd_signed(21),
                               $urandom_range(0, 1 << 23), $urandom_range(0, 1 << 21),
                               $urandom_range(0, 1 << 19));
        end else if (p < 80) begin
            return make_spring($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom, $urandom & mx,
                               $urandom & mx, $urandom & mx);
        end else if (p < 88) begin
            return make_spring(ax, ay, az, ax, ay, az, $urandom, $urandom, $urandom,
                               $urandom & mx, $urandom & mx, $urandom & mx);
        end else begin
            return make_spring(ax, ay, az, ax + rnd_signed(4), ay + rnd_signed(4), az,
                               rnd_signed(28), rnd_signed(28), rnd_signed(28),
                               $urandom & mx, $urandom & mx, $urandom & mx);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) board.note_spring(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) board.check_force(m_axis_tdata, m_axis_tuser);
        end
        if (hold > 0) begin
            hold <= hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            hold <= pick_gap();
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        int unsigned mx;
        int          limit;
        mx = 32'h7fffffff;
        board = new();
        stall_pct = 0;
        hold = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_spring(make_spring(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_spring(make_spring(5, -7, 9, 5, -7, 9, -1, -1, -1, mx, mx, mx));
        send_spring(make_spring(32'h10000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h10000, 0));
        send_spring(make_spring(0, 32'h30000, 0, 0, 0, 0, 0, 32'h8000, 0, 32'h10000,
                                32'h20000, 32'h10000));
        send_spring(make_spring(0, 0, -32'h40000, 0, 0, 0, 0, 0, 32'h10000, 32'h80000,
                                32'h10000, 32'h10000));
        send_spring(make_spring(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                                32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                                32'h7fffffff, 0, mx, mx));
        send_spring(make_spring(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                                32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                                32'h80000000, mx, mx, mx));
        send_spring(make_spring(32'h7fffffff, 0, 0, 32'h80000000, 0, 0, 0, 0, 0, 0, mx, 0));
        send_spring(make_spring(1, 0, 0, 0, 0, 0, 0, 0, 0, mx, mx, 0));
        send_spring(make_spring(1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_spring(make_spring(0, 0, 0, 1, 0, 0, 32'h80000000, 0, 0, 0, 0, mx));
        send_spring(make_spring(32'h40000000, 0, 0, 32'hc0000000, 0, 0, 0, 0, 0, mx, 1, 1));
        send_spring(make_spring(3, 4, 0, 0, 0, 0, 32'h7fffffff, 0, 0, 32'h50000, 0, mx));
        send_spring(make_spring(-1, -1, -1, 0, 0, 0, 1, 1, 1, mx, 32'h10000, 32'h10000));
        send_spring(make_spring(32'h12345678, -32'h1234567, 32'h7654321, 0, 0, 0,
                                32'h100000, -32'h100000, 0, 32'h100000, 32'h4000, 32'h2000));
        send_spring(make_spring(0, 32'h8000, 0, 0, 0, 0, 0, 0, 0, 32'h7fff0000, mx, 0));

        for (int n = 0; n < 1700; n++) begin
            if (n % 400 == 0) stall_pct = (n % 800 == 0) ? 0 : 30;
            else if (n % 400 == 200) stall_pct = 10;
            send_spring(random_spring());
        end
        s_axis_tvalid <= 1'b0;

        limit = 0;
        while (board.pending.size() != 0 && limit < 200000) begin
            @(posedge i_clk);
            limit++;
        end
        repeat (80) @(posedge i_clk);
        if (board.pending.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, board.pending.size());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/sdf_pkg.sv
hw/rtl/sdf_front.sv
hw/rtl/sdf_sqrt.sv
hw/rtl/sdf_div.sv
hw/rtl/sdf_force.sv
hw/rtl/spring_damper_force_core.sv
test/spring_damper_force_core_tb.sv
